// ----- design/psa_pkg.sv -----
// Shared constants and types for the priority scheduler with aging.
package psa_pkg;

    localparam int ID_W    = 6;
    localparam int REM_W   = 8;
    localparam int STAT_W  = 16;
    localparam int NUM_IDS = 64;
    localparam int THR_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CIDX_W  = 2;

    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    localparam logic [CIDX_W-1:0] CFG_PREEMPT   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_AGING_EN  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_AGING_THR = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        logic inc;
    } psa_chain_ctl_t;

endpackage

// ----- design/psa_cell.sv -----
// One queue slot: holds a task record, takes its right neighbor on a shift.
module psa_cell #(
    parameter int DW = 64,
    parameter int SW = 16
) (
    input  logic          clk,
    input  logic          load,
    input  logic          shift,
    input  logic          inc,
    input  logic [DW-1:0] load_data,
    input  logic [DW-1:0] right_data,
    output logic [DW-1:0] data
);

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic [DW-1:0] sel;

    always_comb
    begin
        if (load)
        begin
            sel = load_data;
        end
        else if (shift)
        begin
            sel = right_data;
        end
        else
        begin
            sel = data_reg;
        end
        data_next = sel;
        if (inc && (sel[SW-1:0] != {SW{1'b1}}))
        begin
            data_next[SW-1:0] = sel[SW-1:0] + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- design/psa_chain.sv -----
// One ready-queue level built as a row of cells that shift toward the head.
module psa_chain
    import psa_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int DW    = 64,
    parameter int CW    = 7,
    parameter int SW    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  psa_chain_ctl_t ctl,
    input  logic [DW-1:0]  push_data,
    output logic [DW-1:0]  head,
    output logic [CW-1:0]  count
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] load_idx;
    logic [DW-1:0] cell_data [DEPTH];

    always_comb
    begin
        load_idx   = ctl.pop ? (count_reg - CW'(1)) : count_reg;
        count_next = count_reg + CW'(ctl.push) - CW'(ctl.pop);
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DW-1:0] right;
        if (i == DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid
            assign right = cell_data[i+1];
        end
        psa_cell #(
            .DW(DW),
            .SW(SW)
        ) u_cell (
            .clk       (clk),
            .load      (ctl.push && (CW'(i) == load_idx)),
            .shift     (ctl.pop),
            .inc       (ctl.inc),
            .load_data (push_data),
            .right_data(right),
            .data      (cell_data[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = cell_data[0];
    assign count = count_reg;

endmodule

// ----- design/priority_scheduler_with_aging.sv -----
// Top level: multilevel ready-queue scheduler with aging, one quantum per tick.
// An arrival transaction gives no result and leaves the block idle.
// A tick runs the request step, then with aging a load and scan step for each
// level from LEVELS-1 down to 1, then the pick step; the per-level scan rotates
// that level's cell row one task per cycle, moving aged tasks one level up.
// The result strobe is registered from the pick step and rises as busy falls.
// Reset clears queues, time and held task, and sets config registers to defaults.
module priority_scheduler_with_aging
    import psa_pkg::*;
#(
    parameter int MAX_TASKS = 64,
    parameter int LEVELS    = 4,
    parameter int TIME_BITS = 16,
    localparam int LW       = $clog2(LEVELS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              action,
    input  logic [ID_W-1:0]   task_id,
    input  logic [2:0]        prio_level,
    input  logic [REM_W-1:0]  run_quanta,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output logic              done,
    output logic              idle,
    output logic [ID_W-1:0]   running_task,
    output logic [LW-1:0]     served_level,
    output logic              first_run,
    output logic [STAT_W-1:0] resp_time,
    output logic              finished,
    output logic [STAT_W-1:0] turnaround,
    output logic [STAT_W-1:0] wait_total
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int SW = (TIME_BITS > STAT_W) ? TIME_BITS : STAT_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [TIME_BITS-1:0] stamp;
        logic [TIME_BITS-1:0] arrival;
        logic [REM_W-1:0]     rem;
        logic                 started;
        logic [STAT_W-1:0]    wait_cnt;
    } rec_t;

    localparam int RW = $bits(rec_t);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_REQ   = 5'b00010,
        ST_ALOAD = 5'b00100,
        ST_AGE   = 5'b01000,
        ST_PICK  = 5'b10000
    } state_t;

    function automatic logic [STAT_W-1:0] sat_stat(input logic [TIME_BITS-1:0] v);
        logic [SW-1:0] w;
        w = SW'(v);
        return (w > SW'(STAT_MAX)) ? STAT_MAX : w[STAT_W-1:0];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic                 preempt_reg;
    logic                 aging_reg;
    logic [THR_W-1:0]     thr_reg;
    logic [NUM_IDS-1:0]   active_reg;
    logic [TIME_BITS-1:0] now_reg;
    rec_t                 held_reg;
    logic [LW-1:0]        held_lvl_reg;
    logic                 held_valid_reg;
    logic [LW-1:0]        alvl_reg;
    logic [CW-1:0]        acnt_reg;

    logic              done_reg;
    logic              idle_reg;
    logic [ID_W-1:0]   task_reg;
    logic [LW-1:0]     lvl_reg;
    logic              first_reg;
    logic [STAT_W-1:0] resp_reg;
    logic              fin_reg;
    logic [STAT_W-1:0] turn_reg;
    logic [STAT_W-1:0] wait_reg;

    psa_chain_ctl_t ctl   [LEVELS];
    logic [RW-1:0]  head  [LEVELS];
    logic [CW-1:0]  count [LEVELS];
    rec_t           push_data;

    logic                 accept;
    logic                 arrival_ok;
    logic [LW-1:0]        arr_lvl;
    rec_t                 age_head;
    logic [TIME_BITS-1:0] age_diff;
    logic                 promote;
    logic                 pick_have;
    logic [LW-1:0]        pick_lvl;
    logic                 have;
    rec_t                 run_rec;
    rec_t                 run_upd;
    logic [LW-1:0]        run_lvl;
    logic [REM_W-1:0]     rem_dec;
    logic                 run_fin;
    logic [TIME_BITS-1:0] fin_time;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_level
        psa_chain #(
            .DEPTH(MAX_TASKS),
            .DW   (RW),
            .CW   (CW),
            .SW   (STAT_W)
        ) u_chain (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[g]),
            .push_data(push_data),
            .head     (head[g]),
            .count    (count[g])
        );
    end

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        arrival_ok = accept && !action && (int'(task_id) < MAX_TASKS)
                     && (run_quanta != '0) && !active_reg[task_id];
        if (prio_level == 3'd0)
        begin
            arr_lvl = '0;
        end
        else if (int'(prio_level) > LEVELS)
        begin
            arr_lvl = LW'(LEVELS - 1);
        end
        else
        begin
            arr_lvl = LW'(prio_level - 3'd1);
        end

        age_head = rec_t'(head[alvl_reg]);
        age_diff = now_reg - age_head.stamp;
        promote  = age_diff >= TIME_BITS'(thr_reg);

        pick_have = 1'b0;
        pick_lvl  = '0;
        for (int l = LEVELS - 1; l >= 0; l--)
        begin
            if (count[l] != '0)
            begin
                pick_have = 1'b1;
                pick_lvl  = LW'(l);
            end
        end

        have     = held_valid_reg || pick_have;
        run_rec  = held_valid_reg ? held_reg : rec_t'(head[pick_lvl]);
        run_lvl  = held_valid_reg ? held_lvl_reg : pick_lvl;
        rem_dec  = run_rec.rem - REM_W'(1);
        run_fin  = (rem_dec == '0);
        fin_time = (now_reg == TIME_MAX) ? now_reg : (now_reg + TIME_BITS'(1));
        run_upd         = run_rec;
        run_upd.rem     = rem_dec;
        run_upd.started = 1'b1;
    end

    always_comb
    begin
        for (int l = 0; l < LEVELS; l++)
        begin
            ctl[l] = '0;
        end
        push_data  = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (arrival_ok)
                begin
                    ctl[arr_lvl].push = 1'b1;
                    push_data.id      = task_id;
                    push_data.stamp   = now_reg;
                    push_data.arrival = now_reg;
                    push_data.rem     = run_quanta;
                end
                if (accept && action)
                begin
                    state_next = ST_REQ;
                end
            end
            ST_REQ:
            begin
                if (held_valid_reg && preempt_reg)
                begin
                    ctl[held_lvl_reg].push = 1'b1;
                    push_data              = held_reg;
                end
                state_next = aging_reg ? ST_ALOAD : ST_PICK;
            end
            ST_ALOAD:
            begin
                state_next = ST_AGE;
            end
            ST_AGE:
            begin
                if (acnt_reg == '0)
                begin
                    state_next = (alvl_reg == LW'(1)) ? ST_PICK : ST_ALOAD;
                end
                else
                begin
                    ctl[alvl_reg].pop = 1'b1;
                    push_data         = age_head;
                    if (promote)
                    begin
                        ctl[alvl_reg - LW'(1)].push = 1'b1;
                        push_data.stamp             = now_reg;
                    end
                    else
                    begin
                        ctl[alvl_reg].push = 1'b1;
                    end
                end
            end
            ST_PICK:
            begin
                for (int l = 0; l < LEVELS; l++)
                begin
                    ctl[l].inc = 1'b1;
                end
                if (!held_valid_reg && pick_have)
                begin
                    ctl[pick_lvl].pop = 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            preempt_reg    <= 1'b1;
            aging_reg      <= 1'b0;
            thr_reg        <= THR_W'(5);
            active_reg     <= '0;
            now_reg        <= '0;
            held_valid_reg <= 1'b0;
            held_lvl_reg   <= '0;
            held_reg       <= '0;
            alvl_reg       <= '0;
            acnt_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_PICK);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PREEMPT:   preempt_reg <= cfg_data[0];
                    CFG_AGING_EN:  aging_reg   <= cfg_data[0];
                    CFG_AGING_THR: thr_reg     <= cfg_data;
                    default:       ;
                endcase
            end
            if (arrival_ok && (state_reg == ST_IDLE))
            begin
                active_reg[task_id] <= 1'b1;
            end
            if (state_reg == ST_REQ)
            begin
                if (held_valid_reg && preempt_reg)
                begin
                    held_valid_reg <= 1'b0;
                end
                alvl_reg <= LW'(LEVELS - 1);
            end
            if (state_reg == ST_ALOAD)
            begin
                acnt_reg <= count[alvl_reg];
            end
            if (state_reg == ST_AGE)
            begin
                if (acnt_reg == '0)
                begin
                    alvl_reg <= alvl_reg - LW'(1);
                end
                else
                begin
                    acnt_reg <= acnt_reg - CW'(1);
                end
            end
            if (state_reg == ST_PICK)
            begin
                held_valid_reg <= have && !run_fin;
                if (have)
                begin
                    held_reg     <= run_upd;
                    held_lvl_reg <= run_lvl;
                    if (run_fin)
                    begin
                        active_reg[run_rec.id] <= 1'b0;
                    end
                end
                if (now_reg != TIME_MAX)
                begin
                    now_reg <= now_reg + TIME_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PICK)
        begin
            idle_reg  <= !have;
            task_reg  <= have ? run_rec.id : '0;
            lvl_reg   <= have ? run_lvl : '0;
            first_reg <= have && !run_rec.started;
            resp_reg  <= (have && !run_rec.started) ?
                         sat_stat(now_reg - run_rec.arrival) : '0;
            fin_reg   <= have && run_fin;
            turn_reg  <= (have && run_fin) ? sat_stat(fin_time - run_rec.arrival) : '0;
            wait_reg  <= (have && run_fin) ? run_rec.wait_cnt : '0;
        end
    end

    assign done          = done_reg;
    assign idle          = idle_reg;
    assign running_task  = task_reg;
    assign served_level  = lvl_reg;
    assign first_run     = first_reg;
    assign resp_time     = resp_reg;
    assign finished      = fin_reg;
    assign turnaround    = turn_reg;
    assign wait_total    = wait_reg;

endmodule

// ----- design/psa_checker.sv -----
// Port-level checks for the scheduler, bound to the top level.
module psa_checker
    import psa_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              action,
    input logic              done,
    input logic              idle,
    input logic [ID_W-1:0]   running_task,
    input logic              first_run,
    input logic [STAT_W-1:0] resp_time,
    input logic              finished
);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result strobe without a preceding busy tick");

    a_busy_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && action))
        else $error("busy rose without a tick transaction");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && idle) |-> ((running_task == '0) && !first_run && !finished))
        else $error("idle quantum reports a task");

    a_resp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !first_run) |-> (resp_time == '0))
        else $error("response time given without a first run");

endmodule

bind priority_scheduler_with_aging psa_checker u_psa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .done         (done),
    .idle         (idle),
    .running_task (running_task),
    .first_run    (first_run),
    .resp_time    (resp_time),
    .finished     (finished)
);

// ----- sim/testbench.sv -----
// Testbench for the priority scheduler with aging: random and directed arrivals and ticks,
// checked against a scoreboard that predicts every quantum.
`timescale 1ns / 1ps

module testbench;
    import psa_pkg::*;

    localparam bit ACT_ARRIVAL = 1'b0;
    localparam bit ACT_TICK    = 1'b1;
    localparam int WATCH_LIMIT = 5000;

    typedef struct {
        bit          idle;
        bit [5:0]    task_num;
        bit [1:0]    level;
        bit          first;
        bit [15:0]   resp;
        bit          fin;
        bit [15:0]   turn;
        bit [15:0]   waited;
    } quantum_t;

    class sched_scoreboard;
        bit        preempt = 1;
        bit        aging_on = 0;
        bit [7:0]  threshold = 5;
        int        ready_q[4][$];
        bit [7:0]  remaining[64];
        bit [1:0]  level_of[64];
        bit [15:0] stamp[64];
        bit [15:0] arrived[64];
        bit [15:0] waited[64];
        bit        started[64];
        bit        active[64];
        bit [15:0] now_t = 0;
        int        held = 0;
        bit        held_v = 0;
        quantum_t  pending[$];
        int        errors = 0;
        int        checked = 0;

        function void set_reg(bit [1:0] idx, bit [7:0] val);
            if (idx == CFG_PREEMPT) preempt = val[0];
            else if (idx == CFG_AGING_EN) aging_on = val[0];
            else if (idx == CFG_AGING_THR) threshold = val;
        endfunction

        function void note(bit act, bit [5:0] id, bit [2:0] p, bit [7:0] r);
            quantum_t q;
            int lv;
            int j;
            int t;
            if (act == ACT_ARRIVAL) begin
                if (r == 0 || active[id]) return;
                lv = (p == 0) ? 0 : (p > 4 ? 3 : p - 1);
                active[id] = 1;
                remaining[id] = r;
                level_of[id] = lv;
                stamp[id] = now_t;
                arrived[id] = now_t;
                waited[id] = 0;
                started[id] = 0;
                ready_q[lv].push_back(id);
                return;
            end
            q = '{default: 0};
            if (held_v && preempt) begin
                ready_q[level_of[held]].push_back(held);
                held_v = 0;
            end
            if (aging_on) begin
                for (int l = 3; l > 0; l--) begin
                    j = 0;
                    while (j < ready_q[l].size()) begin
                        t = ready_q[l][j];
                        if (int'(now_t) - int'(stamp[t]) >= int'(threshold)) begin
                            ready_q[l].delete(j);
                            level_of[t] = l - 1;
                            stamp[t] = now_t;
                            ready_q[l-1].push_back(t);
                        end else begin
                            j++;
                        end
                    end
                end
            end
            t = -1;
            if (held_v) begin
                t = held;
            end else begin
                for (int l = 0; l < 4; l++) begin
                    if (t < 0 && ready_q[l].size() > 0) t = ready_q[l].pop_front();
                end
            end
            if (t < 0) begin
                q.idle = 1;
            end else begin
                q.task_num = t;
                q.level = level_of[t];
                if (!started[t]) begin
                    started[t] = 1;
                    q.first = 1;
                    q.resp = now_t - arrived[t];
                end
                remaining[t]--;
                if (remaining[t] == 0) begin
                    q.fin = 1;
                    q.turn = (now_t < 16'hFFFF ? now_t + 16'd1 : now_t) - arrived[t];
                    q.waited = waited[t];
                    active[t] = 0;
                    held_v = 0;
                end else begin
                    held = t;
                    held_v = 1;
                end
            end
            for (int l = 0; l < 4; l++)
                for (int k = 0; k < ready_q[l].size(); k++)
                    if (waited[ready_q[l][k]] != 16'hFFFF) waited[ready_q[l][k]]++;
            if (now_t != 16'hFFFF) now_t++;
            pending.push_back(q);
        endfunction

        function void cmp(string name, int e, int a);
            if (e != a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check(quantum_t a);
            quantum_t e;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no tick outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("idle", e.idle, a.idle);
            cmp("running_task", e.task_num, a.task_num);
            cmp("served_level", e.level, a.level);
            cmp("first_run", e.first, a.first);
            cmp("resp_time", e.resp, a.resp);
            cmp("finished", e.fin, a.fin);
            cmp("turnaround", e.turn, a.turn);
            cmp("wait_total", e.waited, a.waited);
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic action = 0;
    logic [ID_W-1:0] task_id = 0;
    logic [2:0] prio_level = 0;
    logic [REM_W-1:0] run_quanta = 0;
    logic cfg_we = 0;
    logic [CIDX_W-1:0] cfg_index = 0;
    logic [CFG_W-1:0] cfg_data = 0;
    logic done, idle, first_run, finished;
    logic [ID_W-1:0] running_task;
    logic [1:0] served_level;
    logic [STAT_W-1:0] resp_time, turnaround, wait_total;

    sched_scoreboard sb = new();
    int quiet_cycles = 0;
    int sent = 0;
    bit no_gaps = 0;

    priority_scheduler_with_aging dut (.*);

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n && done)
            sb.check('{idle, running_task, served_level, first_run, resp_time,
                       finished, turnaround, wait_total});
    end

    always @(posedge clk) begin
        if ((start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send(bit act, bit [5:0] id, bit [2:0] p, bit [7:0] r);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 99) < 29) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        action <= act;
        task_id <= id;
        prio_level <= p;
        run_quanta <= r;
        do @(posedge clk); while (busy);
        sb.note(act, id, p, r);
        sent++;
    endtask

    task automatic drain();
        start <= 0;
        @(posedge clk);
        while (sb.pending.size() != 0 || busy) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(bit pre, bit age, bit [7:0] thr);
        cfg_we <= 1;
        cfg_index <= CFG_PREEMPT;
        cfg_data <= pre;
        @(posedge clk);
        sb.set_reg(CFG_PREEMPT, pre);
        cfg_index <= CFG_AGING_EN;
        cfg_data <= age;
        @(posedge clk);
        sb.set_reg(CFG_AGING_EN, age);
        cfg_index <= CFG_AGING_THR;
        cfg_data <= thr;
        @(posedge clk);
        sb.set_reg(CFG_AGING_THR, thr);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic random_item();
        bit [7:0] r;
        int roll;
        if ($urandom_range(0, 99) < 60) begin
            send(ACT_TICK, $urandom_range(0, 63), $urandom_range(0, 7), $urandom);
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 5) r = 0;
            else if (roll < 15) r = $urandom_range(9, 255);
            else r = $urandom_range(1, 8);
            send(ACT_ARRIVAL, $urandom_range(0, 63), $urandom_range(0, 7), r);
        end
    endtask

    initial begin
        bit [2:0] modes[7][3];
        bit [7:0] thrs[7];
        modes = '{'{0, 0, 0}, '{1, 1, 0}, '{0, 1, 0}, '{1, 1, 0}, '{0, 0, 0},
                  '{1, 1, 0}, '{0, 1, 0}};
        thrs = '{8'd9, 8'd255, 8'd3, 8'd1, 8'd200, 8'd0, 8'd2};
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(ACT_ARRIVAL, 6'd0, 3'd0, 8'd1);
        send(ACT_ARRIVAL, 6'd63, 3'd7, 8'd255);
        send(ACT_ARRIVAL, 6'd5, 3'd4, 8'd0);
        send(ACT_ARRIVAL, 6'd0, 3'd2, 8'd4);
        send(ACT_ARRIVAL, 6'd1, 3'd1, 8'd3);
        send(ACT_ARRIVAL, 6'd2, 3'd2, 8'd2);
        send(ACT_ARRIVAL, 6'd3, 3'd3, 8'd2);
        send(ACT_ARRIVAL, 6'd42, 3'd4, 8'd1);
        send(ACT_ARRIVAL, 6'd21, 3'd5, 8'd2);
        repeat (8) send(ACT_TICK, 6'h3F, 3'h7, 8'hFF);
        send(ACT_ARRIVAL, 6'd4, 3'd6, 8'd1);
        repeat (6) send(ACT_TICK, 6'd0, 3'd0, 8'd0);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            configure(modes[ph][0][0], modes[ph][1][0], thrs[ph]);
            no_gaps = (ph == 3);
            repeat (240) random_item();
        end

        // Queue a long task and a one-quantum task, then finish with random traffic under aging.
        drain();
        configure(1'b1, 1'b0, 8'd5);
        send(ACT_ARRIVAL, 6'd60, 3'd1, 8'd255);
        send(ACT_ARRIVAL, 6'd61, 3'd2, 8'd1);
        drain();
        configure(1'b0, 1'b1, 8'd4);
        repeat (60) random_item();

        drain();
        repeat (100) @(posedge clk);
        $display("Sent %0d transactions over 9 register settings; %0d results checked.",
                 sent, sb.checked);
        $display("Covered both scheduling modes, aging thresholds 0..255, long tasks.");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
